/* src/wcsa_pkg.sv */
// Shared types and constants for the weighted chi-square accumulator.
// Used by the front queue, the back sequencer and the top level.
package wcsa_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT  = 2'd1;

    // Width of the output count field.
    localparam int OUT_COUNT_W = 24;

    // One classified pixel, as it travels from the front to the back.
    typedef struct packed {
        logic        sat_zero;  // pixel above the saturation level, when that level is positive
        logic        use_gain;  // gain and pixel both positive
        logic [30:0] pix;       // pixel value, valid when use_gain is set
        logic [31:0] var_q;     // background variance
        logic [31:0] mag;       // magnitude of pixel minus model
        logic        last;      // last pixel of the region
    } t_item;

endpackage

/* src/wcsa_front.sv */
// Front part: classifies incoming pixels and holds them in a two-entry queue.
// Depends on wcsa_pkg for the item type.
module wcsa_front
    import wcsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_pixel_value,
    input  logic signed [31:0] i_model_value,
    input  logic [31:0]        i_background_variance,
    input  logic               i_region_end,
    input  logic [31:0]        i_gain,
    input  logic signed [31:0] i_sat,
    output logic               o_valid,
    output t_item              o_item,
    input  logic               i_deq
);

    t_item            r_ent [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    t_item            w_new;
    logic signed [32:0] w_diff;
    logic             w_push;

    // Classify the incoming pixel.
    always_comb begin
        w_diff         = 33'(i_pixel_value) - 33'(i_model_value);
        w_new.sat_zero = (i_sat > 0) && (i_pixel_value > i_sat);
        w_new.use_gain = (i_gain != 32'd0) && (i_pixel_value > 0);
        w_new.pix      = i_pixel_value[30:0];
        w_new.var_q    = i_background_variance;
        w_new.mag      = w_diff[32] ? 32'(-w_diff) : w_diff[31:0];
        w_new.last     = i_region_end;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign w_push  = i_push && !o_full;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_ent[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= w_new;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_deq) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_deq);
        end
    end

endmodule

/* src/wcsa_back.sv */
// Back part: divides, takes the square root, squares and accumulates per pixel.
// Depends on wcsa_pkg; holds one finished result in an output register.
module wcsa_back
    import wcsa_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_item                  i_item,
    output logic                   o_deq,
    input  logic [31:0]            i_gain,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [31:0]            o_pixel_weight,
    output logic [63:0]            o_chi_square_total,
    output logic [OUT_COUNT_W-1:0] o_good_pixel_count,
    output logic                   o_totals_final
);

    localparam int NW  = 31 + FRACTION_BITS;
    localparam int TOP = 48 + FRACTION_BITS;
    localparam int CW  = $clog2(TOP + 1);
    localparam int SH  = FRACTION_BITS + 48;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GDIV = 7'b0000010,
        S_PREP = 7'b0000100,
        S_IDIV = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_ACC  = 7'b1000000
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_cnt;
    t_item            r_item;
    logic [31:0]      r_rem;
    logic [NW-1:0]    r_num;
    logic [63:0]      r_d, r_r, r_q, r_res, r_bit, r_p, r_prod;
    logic             r_over;
    logic [31:0]      r_w;
    logic [127:0]     r_acc;
    logic [1:0]       r_mph;
    logic             r_mhalf;
    logic [63:0]      r_sum;
    logic [COUNT_WIDTH-1:0] r_count;
    logic             r_ovalid;
    logic [31:0]      r_ow;
    logic [63:0]      r_osum;
    logic [OUT_COUNT_W-1:0] r_ocnt;
    logic             r_olast;

    logic [32:0]      w_gt;
    logic             w_gge;
    logic [64:0]      w_it;
    logic             w_ige;
    logic [63:0]      w_sv, w_nres;
    logic             w_sge;
    logic [31:0]      w_ma, w_mb;
    logic [127:0]     w_shift;
    logic [63:0]      w_term, w_nsum;
    logic [64:0]      w_add;
    logic [COUNT_WIDTH-1:0] w_ncount;
    logic             w_slot;

    // Per-step datapath of the shared units.
    always_comb begin
        w_gt  = {r_rem, r_num[NW-1]};
        w_gge = (w_gt >= {1'b0, i_gain});
        w_it  = {r_r, (r_cnt == CW'(0))};
        w_ige = (w_it >= {1'b0, r_d});
        w_sv  = r_res + r_bit;
        w_sge = (r_q >= w_sv);
        w_nres = w_sge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
        case (r_mph)
            2'd0:    begin w_ma = r_item.mag;  w_mb = r_w;        end
            2'd1:    begin w_ma = r_p[31:0];   w_mb = r_p[31:0];  end
            2'd2:    begin w_ma = r_p[63:32];  w_mb = r_p[31:0];  end
            default: begin w_ma = r_p[63:32];  w_mb = r_p[63:32]; end
        endcase
        w_shift  = r_acc >> SH;
        w_term   = (|w_shift[127:64]) ? '1 : w_shift[63:0];
        w_add    = {1'b0, r_sum} + {1'b0, w_term};
        w_nsum   = w_add[64] ? '1 : w_add[63:0];
        w_ncount = ((r_w != 32'd0) && (r_count != '1)) ? r_count + 1'b1 : r_count;
        w_slot   = !r_ovalid || i_pop;
    end

    assign o_deq = (r_state == S_IDLE) && i_valid;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_item;
                        r_cnt  <= '0;
                        r_rem  <= '0;
                        r_num  <= {i_item.pix, FRACTION_BITS'(0)};
                        r_d    <= 64'(i_item.var_q);
                        r_state <= (i_item.use_gain && !i_item.sat_zero) ? S_GDIV : S_PREP;
                    end
                end
                S_GDIV: begin
                    r_rem <= w_gge ? 32'(w_gt - {1'b0, i_gain}) : w_gt[31:0];
                    r_num <= {r_num[NW-2:0], w_gge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NW - 1)) begin
                        r_d     <= 64'(r_item.var_q) + 64'({r_num[NW-2:0], w_gge});
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_cnt   <= '0;
                    r_r     <= '0;
                    r_q     <= '0;
                    r_over  <= 1'b0;
                    r_mph   <= 2'd0;
                    r_mhalf <= 1'b0;
                    if (r_item.sat_zero) begin
                        r_w     <= '0;
                        r_state <= S_MUL;
                    end else if (r_d == 64'd0) begin
                        r_w     <= '1;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_IDIV;
                    end
                end
                S_IDIV: begin
                    r_r    <= w_ige ? 64'(w_it - {1'b0, r_d}) : w_it[63:0];
                    r_q    <= {r_q[62:0], w_ige};
                    r_over <= r_over | r_q[63];
                    if (r_cnt == CW'(TOP)) begin
                        r_cnt   <= '0;
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_over) begin
                        r_w     <= '1;
                        r_state <= S_MUL;
                    end else begin
                        if (w_sge) begin
                            r_q <= r_q - w_sv;
                        end
                        r_res <= w_nres;
                        r_bit <= r_bit >> 2;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CW'(31)) begin
                            r_w     <= w_nres[31:0];
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_mhalf <= !r_mhalf;
                    if (!r_mhalf) begin
                        r_prod <= 64'(w_ma) * 64'(w_mb);
                    end else begin
                        r_mph <= r_mph + 2'd1;
                        case (r_mph)
                            2'd0:    r_p   <= r_prod;
                            2'd1:    r_acc <= {64'd0, r_prod};
                            2'd2:    r_acc <= r_acc + ({64'd0, r_prod} << 33);
                            default: begin
                                r_acc   <= r_acc + ({64'd0, r_prod} << 64);
                                r_state <= S_ACC;
                            end
                        endcase
                    end
                end
                S_ACC: begin
                    if (w_slot) begin
                        r_sum   <= r_item.last ? '0 : w_nsum;
                        r_count <= r_item.last ? '0 : w_ncount;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_ACC) && w_slot) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_ACC) && w_slot) begin
            r_ow    <= r_w;
            r_osum  <= w_nsum;
            r_ocnt  <= OUT_COUNT_W'(w_ncount);
            r_olast <= r_item.last;
        end
    end

    assign o_empty            = !r_ovalid;
    assign o_pixel_weight     = r_ow;
    assign o_chi_square_total = r_osum;
    assign o_good_pixel_count = r_ocnt;
    assign o_totals_final     = r_olast;

endmodule

/* src/weighted_chi_square_accumulator.sv */
// Steps for a pixel that uses the gain: serial gain divider, inverse divider of
// 49+FRACTION_BITS steps, 32-step square root, four multiplies. Without the gain the gain
// divider is skipped; a saturated pixel goes from preparation straight to the multiplies.
// The back sequencer takes one pixel at a time and accepts no new pixel until it is done with
// the last one. Synchronous active-low reset clears the queue, the sums,
// the output register and the configuration registers.
module weighted_chi_square_accumulator
    import wcsa_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic signed [31:0]     i_pixel_value,
    input  logic signed [31:0]     i_model_value,
    input  logic [31:0]            i_background_variance,
    input  logic                   i_region_end,
    output logic                   empty,
    input  logic                   pop,
    output logic [31:0]            o_pixel_weight,
    output logic [63:0]            o_chi_square_total,
    output logic [OUT_COUNT_W-1:0] o_good_pixel_count,
    output logic                   o_totals_final,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    logic [31:0]        r_gain;
    logic signed [31:0] r_sat;
    logic               w_valid, w_deq;
    t_item              w_item;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
            r_sat  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN: r_gain <= i_cfg_data;
                CFG_SAT:  r_sat  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Front classifier and queue.
    wcsa_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_push                (push),
        .o_full                (full),
        .i_pixel_value         (i_pixel_value),
        .i_model_value         (i_model_value),
        .i_background_variance (i_background_variance),
        .i_region_end          (i_region_end),
        .i_gain                (r_gain),
        .i_sat                 (r_sat),
        .o_valid               (w_valid),
        .o_item                (w_item),
        .i_deq                 (w_deq)
    );

    // Back sequencer and accumulator.
    wcsa_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (w_valid),
        .i_item             (w_item),
        .o_deq              (w_deq),
        .i_gain             (r_gain),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_pixel_weight     (o_pixel_weight),
        .o_chi_square_total (o_chi_square_total),
        .o_good_pixel_count (o_good_pixel_count),
        .o_totals_final     (o_totals_final)
    );

    // The result side is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) $past(!i_rst_n) |-> empty)
        else $error("result present after reset");

    // The input queue is not full right after reset.
    a_reset_full: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !full)
        else $error("queue full after reset");

    // A waiting result word holds still until it is popped.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pixel_weight)
            && $stable(o_chi_square_total) && $stable(o_good_pixel_count)
            && $stable(o_totals_final)))
        else $error("waiting result word changed before pop");

endmodule

/* tb/tb_weighted_chi_square_accumulator.sv */
// Self-checking testbench for the weighted chi-square accumulator.
// Depends on wcsa_pkg and the top level; predicts every word with an internal model.
module tb_weighted_chi_square_accumulator;
    import wcsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int STALL_LIMIT = 6000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS = 240;

    // One expected result word.
    typedef struct {
        logic [31:0] weight;
        logic [63:0] chi_total;
        logic [23:0] good_count;
        logic        final_flag;
    } t_totals;

    // Scoreboard with its own copy of registers and running sums.
    class chi_square_scoreboard;
        logic [31:0]        gain_reg;
        logic signed [31:0] sat_reg;
        logic [63:0]        chi_sum;
        logic [23:0]        pos_count;
        t_totals            pending[$];
        int                 mismatches;
        int                 words_checked;

        function void clear();
            gain_reg = '0;
            sat_reg = '0;
            chi_sum = '0;
            pos_count = '0;
            mismatches = 0;
            words_checked = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_GAIN) begin
                gain_reg = data;
            end else if (idx == CFG_SAT) begin
                sat_reg = data;
            end
        endfunction

        // Integer square root of a 64-bit value, bit by bit.
        function automatic logic [31:0] int_root(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] b;
            res = '0;
            b = 64'h4000_0000_0000_0000;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res[31:0];
        endfunction

        // Noise weight in Q8.24: floor(sqrt(2^64 / d)), saturating.
        function automatic logic [31:0] noise_weight(logic signed [31:0] pix,
                                                     logic [31:0] var_q);
            logic [64:0] d;
            logic [64:0] q;
            logic [63:0] scaled;
            if (sat_reg > 0 && pix > sat_reg) return '0;
            d = {33'b0, var_q};
            if (gain_reg != 0 && pix > 0) begin
                scaled = {32'b0, pix} << 16;
                d = d + (scaled / {32'b0, gain_reg});
            end
            if (d == 0) return '1;
            q = {1'b1, 64'b0} / d;
            if (q[64]) return '1;
            return int_root(q[63:0]);
        endfunction

        function void note_pixel(logic signed [31:0] pix, logic signed [31:0] mdl,
                                 logic [31:0] var_q, logic last);
            t_totals             exp_word;
            logic signed [32:0]  resid;
            logic [63:0]         mag;
            logic [127:0]        prod;
            logic [127:0]        sq;
            logic [64:0]         acc;
            exp_word.weight = noise_weight(pix, var_q);
            resid = 33'(pix) - 33'(mdl);
            mag = (resid < 0) ? 64'(-resid) : 64'(resid);
            prod = 128'(mag) * 128'(exp_word.weight);
            sq = prod * prod;
            acc = {1'b0, chi_sum} + {1'b0, sq[127:64]};
            chi_sum = acc[64] ? '1 : acc[63:0];
            if (exp_word.weight != 0 && pos_count != '1) pos_count = pos_count + 1'b1;
            exp_word.chi_total = chi_sum;
            exp_word.good_count = pos_count;
            exp_word.final_flag = last;
            pending.push_back(exp_word);
            if (last) begin
                chi_sum = '0;
                pos_count = '0;
            end
        endfunction

        function void check_result(logic [31:0] weight, logic [63:0] chi_total,
                                   logic [23:0] good_count, logic final_flag);
            t_totals exp_word;
            words_checked++;
            if (pending.size() == 0) begin
                $error("result word with no pixel outstanding");
                mismatches++;
                return;
            end
            exp_word = pending.pop_front();
            if (weight !== exp_word.weight) begin
                $error("pixel_weight expected %h actual %h", exp_word.weight, weight);
                mismatches++;
            end
            if (chi_total !== exp_word.chi_total) begin
                $error("chi_square_total expected %h actual %h",
                       exp_word.chi_total, chi_total);
                mismatches++;
            end
            if (good_count !== exp_word.good_count) begin
                $error("good_pixel_count expected %0d actual %0d",
                       exp_word.good_count, good_count);
                mismatches++;
            end
            if (final_flag !== exp_word.final_flag) begin
                $error("totals_final expected %b actual %b", exp_word.final_flag, final_flag);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   push;
    logic                   full;
    logic signed [31:0]     i_pixel_value;
    logic signed [31:0]     i_model_value;
    logic [31:0]            i_background_variance;
    logic                   i_region_end;
    logic                   empty;
    logic                   pop;
    logic [31:0]            o_pixel_weight;
    logic [63:0]            o_chi_square_total;
    logic [OUT_COUNT_W-1:0] o_good_pixel_count;
    logic                   o_totals_final;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [31:0]            i_cfg_data;

    chi_square_scoreboard score;
    logic calm;
    int   idle_cycles;
    int   pixels_sent;
    int   regions_closed;

    weighted_chi_square_accumulator u_top (.*);

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check each popped word and stall pop in random bursts.
    initial begin : result_side
        int hold;
        hold = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                score.check_result(o_pixel_weight, o_chi_square_total,
                                   o_good_pixel_count, o_totals_final);
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                hold = $urandom_range(0, 6);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no handshake of any kind.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Write one configuration register; only called while the block is idle.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        score.write_register(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one pixel word and wait until it is taken; push stays high afterwards unless a random pause drops it.
    task automatic send_pixel(logic [31:0] pix, logic [31:0] mdl, logic [31:0] var_q,
                              logic last);
        push                  <= 1'b1;
        i_pixel_value         <= pix;
        i_model_value         <= mdl;
        i_background_variance <= var_q;
        i_region_end          <= last;
        do @(posedge i_clk); while (full);
        score.note_pixel(pix, mdl, var_q, last);
        pixels_sent++;
        if (last) regions_closed++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every outstanding word has been popped.
    task automatic drain();
        push <= 1'b0;
        while (score.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_signed();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_variance();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 3);
            3, 4: return $urandom_range(1, 32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] gains[RANDOM_PHASES];
        logic [31:0] sats[RANDOM_PHASES];
        score = new();
        score.clear();
        calm = 1'b0;
        pixels_sent = 0;
        regions_closed = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_pixel_value = '0;
        i_model_value = '0;
        i_background_variance = '0;
        i_region_end = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GAIN;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels at reset configuration: infinite gain, no saturation test.
        send_pixel(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
        send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        drain();

        // Unity gain with a positive saturation level.
        write_cfg(CFG_GAIN, 32'h0001_0000);
        write_cfg(CFG_SAT, 32'h0064_0000);
        send_pixel(32'h0064_0001, 32'h0000_0000, 32'h0001_0000, 1'b0);
        send_pixel(32'h0064_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
        send_pixel(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0000, 1'b0);
        send_pixel(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pixel(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 1'b1);
        drain();

        // Smallest gain, negative saturation level, spare indexes ignored.
        write_cfg(CFG_GAIN, 32'h0000_0001);
        write_cfg(CFG_SAT, 32'h8000_0000);
        write_cfg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_cfg(CFG_SPARE_HI, 32'h1234_5678);
        send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        drain();

        // Largest gain and largest saturation level.
        write_cfg(CFG_GAIN, 32'hFFFF_FFFF);
        write_cfg(CFG_SAT, 32'h7FFF_FFFF);
        send_pixel(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pixel(32'h0000_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b0);
        send_pixel(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0010, 1'b1);
        drain();

        // Random phases, each under its own register setting.
        gains = '{32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h1, 32'h0004_0000, 32'h0000_8000,
                  32'h0, 32'h0002_0000};
        sats = '{32'h0, 32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000,
                 32'hFFFF_0000, 32'h0000_0001, 32'h0020_0000};
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_cfg(CFG_GAIN, (ph == 6) ? $urandom : gains[ph]);
            write_cfg(CFG_SAT, (ph == 6) ? $urandom : sats[ph]);
            if (ph == 3) write_cfg(CFG_SPARE_LO, $urandom);
            if (ph == RANDOM_PHASES - 1) calm = 1'b1;
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                send_pixel(pick_signed(), pick_signed(), pick_variance(),
                           ($urandom_range(0, 9) == 0) || (n == PHASE_PIXELS - 1));
            end
            drain();
        end

        // Let any stray word surface before the verdict.
        repeat (400) @(posedge i_clk);
        $display("Covered %0d pixels in %0d regions, %0d result words checked,",
                 pixels_sent, regions_closed, score.words_checked);
        $display("across %0d register settings including gain and saturation extremes.",
                 RANDOM_PHASES + 4);
        if (score.mismatches == 0 && score.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
